// File: rtl/refcounted_slot_allocator_unit_defines.svh
// Assertion macros used by the checker file of the slot allocator.
`ifndef REFCOUNTED_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define REFCOUNTED_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define RSA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define RSA_NEVER(label, clk, rst_n, expr, msg) \
  `RSA_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

// File: rtl/rsa_pkg.sv
// Types and constants of the reference-counted slot allocator.
`timescale 1ns / 1ps

package rsa_pkg;

  localparam int SLOT_W = 6;
  localparam int LEN_W  = 16;
  localparam int REF_W  = 16;

  localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_GRAB    = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NOT_IN_USE = 2'd2,
    ST_SATURATED  = 2'd3
  } status_e;

  typedef struct packed {
    func_e             func;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  length;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] handle;
    status_e           status;
    logic [REF_W-1:0]  ref_count;
    logic [LEN_W-1:0]  stored_length;
    logic              freed;
  } rsp_t;

endpackage

// File: rtl/refcounted_slot_allocator_unit.sv
// Top level of the reference-counted slot allocator.
`timescale 1ns / 1ps

// A command is taken at every clock edge where start is high; busy is never
// raised, so one command per cycle is sustained. The command edge captures
// the command together with the slot's count, length and the free-stack top
// from registered memory ports. Short logic then updates them and registers
// the result, which sits on rsp_o with done_o high for exactly one cycle. It
// must be taken then because the receiver cannot stall. Back-to-back
// commands on the same slot are served through write-to-read bypass. SLOTS
// may range from 2 to 64, limited by the 6-bit slot handle. LEN_BITS may
// range from 4 to 32. Lengths are kept at that width and reported in the
// 16-bit length field.
module refcounted_slot_allocator_unit #(
  parameter int SLOTS    = 64,
  parameter int LEN_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rsa_pkg::cmd_t cmd_i,
  output logic          done_o,
  output rsa_pkg::rsp_t rsp_o
);

  import rsa_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int FC_W  = $clog2(SLOTS + 1);

  // Storage.
  logic [REF_W-1:0]    cnt_mem [SLOTS];
  logic [LEN_BITS-1:0] len_mem [SLOTS];
  logic [IDX_W-1:0]    stk_mem [SLOTS];
  logic [SLOTS-1:0]    cnt_vld_q;
  logic [SLOTS-1:0]    stk_vld_q;
  logic [FC_W-1:0]     fc_q, fc_d;

  // First stage.
  logic                s1_valid_q;
  func_e               s1_func_q;
  logic [SLOT_W-1:0]   s1_slot_q;
  logic [IDX_W-1:0]    s1_idx_q;
  logic                s1_inrange_q;
  logic [LEN_BITS-1:0] s1_len_q;
  logic [REF_W-1:0]    cnt_rd_q;
  logic                cnt_vld_rd_q;
  logic [LEN_BITS-1:0] len_rd_q;
  logic [IDX_W-1:0]    stk_rd_q;
  logic                stk_vld_rd_q;
  logic [IDX_W-1:0]    stk_addr_q;

  // Result.
  logic done_q;
  rsp_t rsp_q, rsp_d;

  logic             accept;
  logic             in_range;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] top_idx;

  logic                cnt_we;
  logic [IDX_W-1:0]    cnt_wa;
  logic [REF_W-1:0]    cnt_wd;
  logic                len_we;
  logic [LEN_BITS-1:0] len_wd;
  logic                stk_we;
  logic [IDX_W-1:0]    stk_wa;
  logic [IDX_W-1:0]    stk_wd;

  logic [REF_W-1:0] cnt_cur;
  logic [REF_W-1:0] cnt_dec;
  logic             in_use;
  logic [IDX_W-1:0] alloc_idx;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign in_range = 32'(cmd_i.slot) < SLOTS;
  assign rd_idx   = in_range ? IDX_W'(cmd_i.slot) : '0;
  // The stack top seen by the next command follows the update made this cycle.
  assign top_idx  = (fc_d == '0) ? '0 : IDX_W'(fc_d - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      done_q     <= 1'b0;
      fc_q       <= FC_W'(SLOTS);
      cnt_vld_q  <= '0;
      stk_vld_q  <= '0;
    end else begin
      s1_valid_q <= accept;
      done_q     <= s1_valid_q;
      fc_q       <= fc_d;
      if (cnt_we) begin
        cnt_vld_q[cnt_wa] <= 1'b1;
      end
      if (stk_we) begin
        stk_vld_q[stk_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q    <= cmd_i.func;
      s1_slot_q    <= cmd_i.slot;
      s1_idx_q     <= rd_idx;
      s1_inrange_q <= in_range;
      s1_len_q     <= LEN_BITS'(cmd_i.length);
    end
    rsp_q <= rsp_d;
  end

  // Count memory with write-first read.
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_we && cnt_wa == rd_idx) begin
      cnt_rd_q     <= cnt_wd;
      cnt_vld_rd_q <= 1'b1;
    end else begin
      cnt_rd_q     <= cnt_mem[rd_idx];
      cnt_vld_rd_q <= cnt_vld_q[rd_idx];
    end
  end

  // Length memory, written together with the count on allocate.
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[cnt_wa] <= len_wd;
    end
    if (len_we && cnt_wa == rd_idx) begin
      len_rd_q <= len_wd;
    end else begin
      len_rd_q <= len_mem[rd_idx];
    end
  end

  // Free stack; an entry never written holds its own index.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_addr_q <= top_idx;
    if (stk_we && stk_wa == top_idx) begin
      stk_rd_q     <= stk_wd;
      stk_vld_rd_q <= 1'b1;
    end else begin
      stk_rd_q     <= stk_mem[top_idx];
      stk_vld_rd_q <= stk_vld_q[top_idx];
    end
  end

  assign cnt_cur   = cnt_vld_rd_q ? cnt_rd_q : '0;
  assign cnt_dec   = cnt_cur - 1'b1;
  assign in_use    = s1_inrange_q && (cnt_cur != '0);
  assign alloc_idx = stk_vld_rd_q ? stk_rd_q : stk_addr_q;

  always_comb begin
    fc_d   = fc_q;
    cnt_we = 1'b0;
    cnt_wa = s1_idx_q;
    cnt_wd = '0;
    len_we = 1'b0;
    len_wd = s1_len_q;
    stk_we = 1'b0;
    stk_wa = IDX_W'(fc_q);
    stk_wd = s1_idx_q;
    rsp_d  = '0;
    if (s1_valid_q) begin
      if (s1_func_q == FUNC_ALLOC) begin
        if (fc_q == '0) begin
          rsp_d.status = ST_FULL;
        end else begin
          fc_d                = fc_q - 1'b1;
          cnt_we              = 1'b1;
          cnt_wa              = alloc_idx;
          cnt_wd              = REF_W'(1);
          len_we              = 1'b1;
          rsp_d.handle        = SLOT_W'(alloc_idx);
          rsp_d.status        = ST_OK;
          rsp_d.ref_count     = REF_W'(1);
          rsp_d.stored_length = LEN_W'(s1_len_q);
        end
      end else if (!in_use) begin
        rsp_d.handle = s1_slot_q;
        rsp_d.status = ST_NOT_IN_USE;
      end else begin
        rsp_d.handle        = s1_slot_q;
        rsp_d.status        = ST_OK;
        rsp_d.ref_count     = cnt_cur;
        rsp_d.stored_length = LEN_W'(len_rd_q);
        unique case (s1_func_q) inside
          FUNC_GRAB: begin
            if (cnt_cur == REF_MAX) begin
              rsp_d.status = ST_SATURATED;
            end else begin
              cnt_we          = 1'b1;
              cnt_wd          = cnt_cur + 1'b1;
              rsp_d.ref_count = cnt_cur + 1'b1;
            end
          end
          FUNC_RELEASE: begin
            cnt_we          = 1'b1;
            cnt_wd          = cnt_dec;
            rsp_d.ref_count = cnt_dec;
            // The last reference hands the slot back to the free stack.
            if (cnt_dec == '0 && fc_q < FC_W'(SLOTS)) begin
              stk_we      = 1'b1;
              fc_d        = fc_q + 1'b1;
              rsp_d.freed = 1'b1;
            end
          end
          FUNC_QUERY, FUNC_ALLOC: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: rtl/rsa_checker.sv
// Port-level checker for the slot allocator and its bind statement.
`timescale 1ns / 1ps
`include "refcounted_slot_allocator_unit_defines.svh"

module rsa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input rsa_pkg::cmd_t cmd_i,
  input logic          done_o,
  input rsa_pkg::rsp_t rsp_o
);

  import rsa_pkg::*;

  logic acc;
  logic other_acc;
  logic not_full_rsp;
  logic freed_bad;
  logic full_dirty;

  assign acc          = start && !busy;
  assign other_acc    = acc && (cmd_i.func != FUNC_ALLOC);
  assign not_full_rsp = rsp_o.status != ST_FULL;
  assign freed_bad    = done_o && rsp_o.freed &&
                        (rsp_o.status != ST_OK || rsp_o.ref_count != '0);
  assign full_dirty   = done_o && rsp_o.status == ST_FULL &&
                        (rsp_o.handle != '0 || rsp_o.ref_count != '0 ||
                         rsp_o.stored_length != '0 || rsp_o.freed);

  // Every transaction produces exactly one result, and no result comes without one.
  `RSA_ASSERT(a_result_follows, clk_i, rst_ni, acc |-> ##2 done_o, "missing result")
  `RSA_ASSERT(a_no_spurious, clk_i, rst_ni, !acc |-> ##2 !done_o, "unexpected result")
  // Only an allocate can find the pool full.
  `RSA_ASSERT(a_full_alloc_only, clk_i, rst_ni, other_acc |-> ##2 not_full_rsp, "full on non-alloc")
  `RSA_NEVER(a_freed_ok, clk_i, rst_ni, freed_bad, "freed with live count")
  `RSA_NEVER(a_full_zero, clk_i, rst_ni, full_dirty, "pool full result not zero")

endmodule

bind refcounted_slot_allocator_unit rsa_checker u_rsa_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .cmd_i  (cmd_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

// File: bench/tb_top.sv
// Self-checking testbench for the reference-counted slot allocator unit.
`timescale 1ns / 1ps

module tb_top;
  import rsa_pkg::*;

  localparam int NUM_SLOTS    = 64;
  localparam int RAND_PER_PH  = 500;
  localparam int LIMIT_CYCLES = 1000000;

  typedef struct {
    func_e             func;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  length;
    int                reps;
    bit                typed;
    rsp_t              ans;
  } op_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  cmd_t cmd_i;
  logic done_o;
  rsp_t rsp_o;

  // Typed-in answer that travels with the transaction being driven.
  bit   row_typed;
  rsp_t row_answer;

  // Shadow of the allocator state.
  logic [REF_W-1:0]  use_cnt  [NUM_SLOTS];
  logic [LEN_W-1:0]  slot_len [NUM_SLOTS];
  logic [SLOT_W-1:0] free_stk [NUM_SLOTS];
  logic [6:0]        free_top;

  rsp_t    pending_rsp_q [$];
  rsp_t    predicted;
  op_row_t plan [$];
  int      sender_idle_pct;
  bit      filling;
  int      mismatches;
  int      cycles;
  int      n_items, n_alloc, n_full, n_not_in_use, n_saturated, n_freed;

  refcounted_slot_allocator_unit #(
    .SLOTS   (NUM_SLOTS),
    .LEN_BITS(LEN_W)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_rsp_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void reset_shadow();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      use_cnt[i]  = '0;
      slot_len[i] = '0;
      free_stk[i] = SLOT_W'(i);
    end
    free_top = 7'(NUM_SLOTS);
  endfunction

  // Applies one command to the shadow state and returns the answer it earns.
  function automatic rsp_t compute_slot_response(cmd_t c);
    rsp_t r;
    r = '0;
    if (c.func == FUNC_ALLOC) begin
      if (free_top == 0) begin
        r.status = ST_FULL;
      end else begin
        free_top           = free_top - 7'd1;
        r.handle           = free_stk[free_top[SLOT_W-1:0]];
        use_cnt[r.handle]  = REF_W'(1);
        slot_len[r.handle] = c.length;
        r.status           = ST_OK;
        r.ref_count        = REF_W'(1);
        r.stored_length    = c.length;
      end
    end else begin
      r.handle = c.slot;
      if (use_cnt[c.slot] == 0) begin
        r.status = ST_NOT_IN_USE;
      end else begin
        r.status        = ST_OK;
        r.stored_length = slot_len[c.slot];
        if (c.func == FUNC_GRAB) begin
          if (use_cnt[c.slot] == REF_MAX) begin
            r.status = ST_SATURATED;
          end else begin
            use_cnt[c.slot] = use_cnt[c.slot] + 1'b1;
          end
        end else if (c.func == FUNC_RELEASE) begin
          use_cnt[c.slot] = use_cnt[c.slot] - 1'b1;
          if (use_cnt[c.slot] == 0 && free_top < NUM_SLOTS) begin
            free_stk[free_top[SLOT_W-1:0]] = c.slot;
            free_top = free_top + 7'd1;
            r.freed  = 1'b1;
          end
        end
        r.ref_count = use_cnt[c.slot];
      end
    end
    return r;
  endfunction

  function automatic rsp_t answer(logic [SLOT_W-1:0] h, status_e st, logic [REF_W-1:0] n,
                                  logic [LEN_W-1:0] len, logic fr);
    answer = '{h, st, n, len, fr};
  endfunction

  function automatic op_row_t op_row(func_e f, logic [SLOT_W-1:0] s, logic [LEN_W-1:0] len,
                                     int reps, bit typed, rsp_t ans);
    op_row_t row;
    row.func   = f;
    row.slot   = s;
    row.length = len;
    row.reps   = reps;
    row.typed  = typed;
    row.ans    = ans;
    return row;
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return LEN_W'(1) << $urandom_range(LEN_W - 1);
      default: return LEN_W'($urandom);
    endcase
  endfunction

  // Mostly slots that are in use, so grab and release get past the free check.
  function automatic logic [SLOT_W-1:0] pick_slot();
    logic [SLOT_W-1:0] s;
    s = SLOT_W'($urandom_range(NUM_SLOTS - 1));
    if ($urandom_range(99) < 85) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (use_cnt[s] != 0) break;
        s = s + 1'b1;
      end
    end
    return s;
  endfunction

  // Alternates between filling the pool up to full and draining it again.
  function automatic cmd_t pick_random_cmd();
    cmd_t c;
    int   roll;
    if (free_top == 0) filling = 1'b0;
    else if (free_top >= 56) filling = 1'b1;
    roll     = $urandom_range(99);
    c.slot   = pick_slot();
    c.length = pick_length();
    if (roll < (filling ? 50 : 10)) c.func = FUNC_ALLOC;
    else if (roll < (filling ? 65 : 20)) c.func = FUNC_GRAB;
    else if (roll < (filling ? 85 : 80)) c.func = FUNC_RELEASE;
    else c.func = FUNC_QUERY;
    return c;
  endfunction

  // Drives one transaction and returns once it has been taken.
  task automatic issue(input cmd_t c, input bit fresh, input bit typed, input rsp_t ans);
    logic [$bits(cmd_t)-1:0] noise;
    cmd_t                    cur;
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      noise = $bits(cmd_t)'($urandom);
      start <= 1'b0;
      cmd_i <= noise;
    end
    @(negedge clk_i);
    cur = fresh ? pick_random_cmd() : c;
    start      <= 1'b1;
    cmd_i      <= cur;
    row_typed  <= typed;
    row_answer <= ans;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input logic [47:0] want,
                               input logic [47:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at cycle %0d in %s: expected %0h, got %0h", cycles, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Check the result first so that a stray strobe cannot consume the
      // expectation of a transaction taken at this same edge.
      if (done_o) begin
        if (pending_rsp_q.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0, 48'(rsp_o));
        end else begin
          predicted = pending_rsp_q.pop_front();
          if (rsp_o.handle !== predicted.handle)
            note_mismatch("handle", 48'(predicted.handle), 48'(rsp_o.handle));
          if (rsp_o.status !== predicted.status)
            note_mismatch("status", 48'(predicted.status), 48'(rsp_o.status));
          if (rsp_o.ref_count !== predicted.ref_count)
            note_mismatch("ref_count", 48'(predicted.ref_count), 48'(rsp_o.ref_count));
          if (rsp_o.stored_length !== predicted.stored_length)
            note_mismatch("stored_length", 48'(predicted.stored_length),
                          48'(rsp_o.stored_length));
          if (rsp_o.freed !== predicted.freed)
            note_mismatch("freed", 48'(predicted.freed), 48'(rsp_o.freed));
        end
      end
      if (start && !busy) begin
        predicted = compute_slot_response(cmd_i);
        n_items++;
        case (predicted.status)
          ST_FULL:       n_full++;
          ST_NOT_IN_USE: n_not_in_use++;
          ST_SATURATED:  n_saturated++;
          default:       if (cmd_i.func == FUNC_ALLOC) n_alloc++;
        endcase
        if (predicted.freed) n_freed++;
        pending_rsp_q.push_back(row_typed ? row_answer : predicted);
      end
    end
  end

  initial begin
    start           = 1'b0;
    cmd_i           = '0;
    row_typed       = 1'b0;
    row_answer      = '0;
    rst_ni          = 1'b0;
    sender_idle_pct = 19;
    filling         = 1'b0;
    reset_shadow();

    // Slot 0 comes off the stack last; it then takes a few extra references.
    plan.push_back(op_row(FUNC_QUERY, 6'd0, 16'h0000, 1, 1,
                          answer(6'd0, ST_NOT_IN_USE, 16'd0, 16'd0, 1'b0)));
    plan.push_back(op_row(FUNC_RELEASE, 6'd63, 16'hFFFF, 1, 1,
                          answer(6'd63, ST_NOT_IN_USE, 16'd0, 16'd0, 1'b0)));
    plan.push_back(op_row(FUNC_GRAB, 6'd17, 16'h0000, 1, 1,
                          answer(6'd17, ST_NOT_IN_USE, 16'd0, 16'd0, 1'b0)));
    plan.push_back(op_row(FUNC_ALLOC, 6'd0, 16'hFFFF, 1, 1,
                          answer(6'd63, ST_OK, 16'd1, 16'hFFFF, 1'b0)));
    plan.push_back(op_row(FUNC_ALLOC, 6'd63, 16'h0000, 1, 1,
                          answer(6'd62, ST_OK, 16'd1, 16'h0000, 1'b0)));
    plan.push_back(op_row(FUNC_QUERY, 6'd63, 16'h0000, 1, 1,
                          answer(6'd63, ST_OK, 16'd1, 16'hFFFF, 1'b0)));
    plan.push_back(op_row(FUNC_GRAB, 6'd62, 16'hFFFF, 1, 1,
                          answer(6'd62, ST_OK, 16'd2, 16'h0000, 1'b0)));
    plan.push_back(op_row(FUNC_RELEASE, 6'd62, 16'h0000, 1, 1,
                          answer(6'd62, ST_OK, 16'd1, 16'h0000, 1'b0)));
    plan.push_back(op_row(FUNC_RELEASE, 6'd62, 16'h0000, 1, 1,
                          answer(6'd62, ST_OK, 16'd0, 16'h0000, 1'b1)));
    plan.push_back(op_row(FUNC_RELEASE, 6'd62, 16'h0000, 1, 1,
                          answer(6'd62, ST_NOT_IN_USE, 16'd0, 16'd0, 1'b0)));
    plan.push_back(op_row(FUNC_ALLOC, 6'd5, 16'h1234, 1, 1,
                          answer(6'd62, ST_OK, 16'd1, 16'h1234, 1'b0)));
    plan.push_back(op_row(FUNC_QUERY, 6'd62, 16'h0000, 1, 1,
                          answer(6'd62, ST_OK, 16'd1, 16'h1234, 1'b0)));
    plan.push_back(op_row(FUNC_ALLOC, 6'd9, 16'hA5A5, 62, 0, '0));
    plan.push_back(op_row(FUNC_ALLOC, 6'h3F, 16'hFFFF, 1, 1,
                          answer(6'd0, ST_FULL, 16'd0, 16'd0, 1'b0)));
    plan.push_back(op_row(FUNC_GRAB, 6'd0, 16'h0000, 3, 0, '0));
    plan.push_back(op_row(FUNC_QUERY, 6'd0, 16'h0000, 1, 0, '0));
    plan.push_back(op_row(FUNC_RELEASE, 6'd0, 16'h0000, 2, 0, '0));
    plan.push_back(op_row(FUNC_RELEASE, 6'd63, 16'h0000, 1, 1,
                          answer(6'd63, ST_OK, 16'd0, 16'hFFFF, 1'b1)));
    plan.push_back(op_row(FUNC_ALLOC, 6'd0, 16'h8000, 1, 1,
                          answer(6'd63, ST_OK, 16'd1, 16'h8000, 1'b0)));
    plan.push_back(op_row(FUNC_RELEASE, 6'd63, 16'h0000, 1, 1,
                          answer(6'd63, ST_OK, 16'd0, 16'h8000, 1'b1)));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      for (int rep = 0; rep < plan[i].reps; rep++) begin
        issue('{plan[i].func, plan[i].slot, plan[i].length}, 1'b0, plan[i].typed,
              plan[i].ans);
      end
    end
    drain();

    // Random traffic: sender idles a little, then often, then never.
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 63 : 0;
      for (int n = 0; n < RAND_PER_PH; n++) begin
        issue('0, 1'b1, 1'b0, '0);
      end
      drain();
    end

    repeat (6) @(posedge clk_i);
    $display("%0d transactions: %0d allocations, %0d pool full, %0d on free slots,",
             n_items, n_alloc, n_full, n_not_in_use);
    $display("%0d saturated grabs, %0d slots returned to the free stack, %0d mismatches",
             n_saturated, n_freed, mismatches);
    if (mismatches == 0 && pending_rsp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
